// ----- design/vls_pkg.sv -----
// ============================================================================
// vls_pkg: shared types and constants for the voxel light splat block
// Holds the command codes, register indexes, default sizes and the request
// and response records between the sequencer and the shared arithmetic unit.
// ============================================================================
package vls_pkg;

  // Default grid size and splat span
  localparam int unsigned GRID_SIDE_DEF = 64;
  localparam int unsigned MAX_SPLAT_DEF = 8;

  // Datapath width of the shared unit and width of its step counter
  localparam int unsigned UW    = 64;
  localparam int unsigned STEPW = 6;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 240;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INJECT = 2'd1,
    CMD_READ   = 2'd2
  } vls_cmd_e;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } vls_op_e;

  // Start request for the shared unit
  typedef struct packed {
    logic             start;
    vls_op_e          op;
    logic [UW-1:0]    rem;
    logic [UW-1:0]    tinit;
    logic [STEPW-1:0] steps;
  } vls_ureq_t;

  // Status and result of the shared unit
  typedef struct packed {
    logic          busy;
    logic [UW-1:0] acc;
  } vls_ursp_t;

endpackage

// ----- design/voxel_light_splat.sv -----
// ============================================================================
// voxel_light_splat: RGBA voxel grid with point light injection
// Sequencer, grid memory and bounds registers around one shared
// divide / square root unit.
// ============================================================================
//
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tuser: command; tdata: light, read index
// m_axis    out  m_axis_tvalid/tready    tdata: RGBA; tuser: light_taken
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Clear: one memory word per cycle. Inject: a setup of axis mapping and span
// divides, then per voxel of the cube square root, multiply, divide in the
// shared unit, then read and write of the grid memory; only the read and write
// when the bounds are empty, and no divide and no write for voxels beyond the
// light's reach. After reset a clearing pass runs before the first item is
// taken; configuration writes are taken at any time. A waiting result does not
// block the next input transfer.
//
module voxel_light_splat #(
  parameter int unsigned GRID_SIDE        = vls_pkg::GRID_SIDE_DEF,
  parameter int unsigned MAX_SPLAT_RADIUS = vls_pkg::MAX_SPLAT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, pos_z, light_radius, color_red, color_green, color_blue,
  // expire_time, now_time, voxel_index, zero pad
  input  logic [vls_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // command
  input  logic [vls_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [vls_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // light_taken
  output logic [vls_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vls_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  localparam int unsigned UW       = vls_pkg::UW;
  localparam int unsigned SIDE     = GRID_SIDE;
  localparam int unsigned MAXR     = MAX_SPLAT_RADIUS;
  localparam int unsigned VOXELS   = SIDE * SIDE * SIDE;
  localparam int unsigned AW       = $clog2(VOXELS);
  localparam int unsigned VW       = $clog2(SIDE);
  localparam int unsigned QA       = VW;
  localparam int unsigned QS       = $clog2(MAXR) + 1;
  localparam int unsigned SPW      = $clog2(MAXR + 1);
  localparam int unsigned D2W      = $clog2(3 * MAXR * MAXR + 1);
  localparam int unsigned NW       = D2W + 32;
  localparam int unsigned SE       = ((NW + 1) / 2) * 2 - 2;
  localparam int unsigned SQ_STEPS = SE / 2 + 1;
  localparam int unsigned DQW      = (NW + 1) / 2;
  localparam int unsigned IXW      = (AW > 18) ? AW : 18;
  localparam int unsigned BW       = VW + SPW + 2;
  localparam int unsigned DW       = VW + 2;

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_CLEAR  = 17'h00002,
    ST_AXIS   = 17'h00004,
    ST_AXWAIT = 17'h00008,
    ST_SPAN   = 17'h00010,
    ST_SPWAIT = 17'h00020,
    ST_BOUND  = 17'h00040,
    ST_VOX    = 17'h00080,
    ST_SQWAIT = 17'h00100,
    ST_MUL    = 17'h00200,
    ST_ATWAIT = 17'h00400,
    ST_VRD    = 17'h00800,
    ST_VWR    = 17'h01000,
    ST_NEXT   = 17'h02000,
    ST_RREAD  = 17'h04000,
    ST_RDATA  = 17'h08000,
    ST_DONE   = 17'h10000
  } vls_state_e;

  // Control registers
  vls_state_e              state_q, state_d;
  logic                    clr_cmd_q, clr_cmd_d;
  logic                    out_valid_q, out_valid_d;
  logic [2:0][31:0]        bnd_lo_q, bnd_lo_d;
  logic [2:0][31:0]        bnd_hi_q, bnd_hi_d;

  // Working registers
  logic [AW-1:0]           clr_q, clr_d;
  logic [2:0][31:0]        pos_q, pos_d;
  logic [31:0]             rad_q, rad_d;
  logic [2:0][7:0]         col_q, col_d;
  logic [IXW-1:0]          idx_q, idx_d;
  logic [1:0]              a_q, a_d;
  logic signed [32:0]      ext_q, ext_d;
  logic [2:0][VW-1:0]      v_q, v_d;
  logic [SPW-1:0]          span_q, span_d;
  logic [2:0][VW-1:0]      lo_q, lo_d;
  logic [2:0][VW:0]        hi_q, hi_d;
  logic [VW-1:0]           x_q, x_d, y_q, y_d, z_q, z_d;
  logic [DQW+31:0]         prod_q, prod_d;
  logic [16:0]             aq_q, aq_d;
  logic [31:0]             res_rgba_q, res_rgba_d;
  logic                    res_taken_q, res_taken_d;
  logic [31:0]             out_rgba_q, out_rgba_d;
  logic                    out_taken_q, out_taken_d;

  // Grid memory
  logic [31:0]             voxel_mem [VOXELS];
  logic [31:0]             rdata_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [31:0]             mem_wdata;
  logic [AW-1:0]           mem_raddr;

  // Shared unit
  vls_pkg::vls_ureq_t      ureq;
  vls_pkg::vls_ursp_t      ursp;

  // Datapath terms
  logic                    in_fire;
  vls_pkg::vls_cmd_e       cmd_in;
  logic signed [32:0]      size_s, s_clamp, diff_s;
  logic [32:0]             mag;
  logic [UW-1:0]           mag_side;
  logic                    ax_far, ax_neg_out;
  logic                    ext_le0;
  logic [31:0]             ext_pos;
  logic [UW-1:0]           denom, den16, ext_max;
  logic [2:0][VW-1:0]      lo_c;
  logic [2:0][VW:0]        hi_c;
  logic signed [BW-1:0]    b_vs [3];
  logic signed [BW-1:0]    b_lo [3];
  logic signed [BW-1:0]    b_hi [3];
  logic signed [BW-1:0]    b_sp;
  logic [AW-1:0]           vox_addr;
  logic signed [DW-1:0]    dx, dy, dz;
  logic [D2W-1:0]          d2;
  logic [DQW+31:0]         mul_w;
  logic [VW:0]             x1, y1, z1;
  logic [24:0]             pr_r, pr_g, pr_b;
  logic [9:0]              sum_r, sum_g, sum_b;
  logic [7:0]              new_r, new_g, new_b;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign cmd_in        = vls_pkg::vls_cmd_e'(s_axis_tuser);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rgba_q;
  assign m_axis_tuser  = out_taken_q;

  // Map one axis of the light into voxel space
  always_comb begin
    size_s   = $signed({bnd_hi_q[a_q][31], bnd_hi_q[a_q]})
             - $signed({bnd_lo_q[a_q][31], bnd_lo_q[a_q]});
    s_clamp  = (size_s < 33'sd65536) ? 33'sd65536 : size_s;
    diff_s   = $signed({pos_q[a_q][31], pos_q[a_q]})
             - $signed({bnd_lo_q[a_q][31], bnd_lo_q[a_q]});
    mag      = diff_s[32] ? 33'(-diff_s) : 33'(diff_s);
    mag_side = UW'(mag) * UW'(SIDE);
    ax_far     = (mag >= 33'(s_clamp));
    ax_neg_out = (mag_side >= UW'(33'(s_clamp)));
  end

  // Span and attenuation terms
  assign ext_le0 = ext_q[32] || (ext_q == 33'sd0);
  assign ext_pos = ext_q[31:0];
  assign denom   = UW'(rad_q[30:0]) * UW'(SIDE);
  assign den16   = denom << 16;
  assign ext_max = UW'(ext_pos) * UW'(MAXR);

  // Clip the cube to the grid
  always_comb begin
    b_sp = $signed({{(BW-SPW){1'b0}}, span_q});
    for (int a = 0; a < 3; a++) begin
      b_vs[a] = $signed({{(BW-VW){1'b0}}, v_q[a]});
      b_lo[a] = b_vs[a] - b_sp;
      b_hi[a] = b_vs[a] + b_sp;
      lo_c[a] = (b_lo[a] < 0) ? '0 : b_lo[a][VW-1:0];
      hi_c[a] = (b_hi[a] > $signed(BW'(SIDE))) ? (VW+1)'(SIDE) : b_hi[a][VW:0];
    end
  end

  // Voxel address and squared offset
  always_comb begin
    vox_addr = AW'(z_q) * AW'(SIDE * SIDE) + AW'(y_q) * AW'(SIDE) + AW'(x_q);
    dx = $signed({2'b00, x_q}) - $signed({2'b00, v_q[0]});
    dy = $signed({2'b00, y_q}) - $signed({2'b00, v_q[1]});
    dz = $signed({2'b00, z_q}) - $signed({2'b00, v_q[2]});
    d2 = D2W'(dx * dx) + D2W'(dy * dy) + D2W'(dz * dz);
  end

  assign mul_w = {32'b0, ursp.acc[DQW-1:0]} * {{DQW{1'b0}}, ext_pos};

  // Walk counters
  assign x1 = {1'b0, x_q} + 1'b1;
  assign y1 = {1'b0, y_q} + 1'b1;
  assign z1 = {1'b0, z_q} + 1'b1;

  // Attenuated color with saturation
  always_comb begin
    pr_r  = {17'b0, col_q[0]} * {8'b0, aq_q};
    pr_g  = {17'b0, col_q[1]} * {8'b0, aq_q};
    pr_b  = {17'b0, col_q[2]} * {8'b0, aq_q};
    sum_r = {2'b00, rdata_q[7:0]}   + {1'b0, pr_r[24:16]};
    sum_g = {2'b00, rdata_q[15:8]}  + {1'b0, pr_g[24:16]};
    sum_b = {2'b00, rdata_q[23:16]} + {1'b0, pr_b[24:16]};
    new_r = (sum_r > 10'd255) ? 8'd255 : sum_r[7:0];
    new_g = (sum_g > 10'd255) ? 8'd255 : sum_g[7:0];
    new_b = (sum_b > 10'd255) ? 8'd255 : sum_b[7:0];
  end

  assign mem_raddr = (state_q == ST_RREAD) ? idx_q[AW-1:0] : vox_addr;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_cmd_d   = clr_cmd_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    bnd_lo_d    = bnd_lo_q;
    bnd_hi_d    = bnd_hi_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    rad_d       = rad_q;
    col_d       = col_q;
    idx_d       = idx_q;
    a_d         = a_q;
    ext_d       = ext_q;
    v_d         = v_q;
    span_d      = span_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    prod_d      = prod_q;
    aq_d        = aq_q;
    res_rgba_d  = res_rgba_q;
    res_taken_d = res_taken_q;
    out_rgba_d  = out_rgba_q;
    out_taken_d = out_taken_q;
    ureq        = '0;
    mem_we      = 1'b0;
    mem_waddr   = vox_addr;
    mem_wdata   = {8'd255, new_b, new_g, new_r};

    // Configuration writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        vls_pkg::CFG_MIN_X: bnd_lo_d[0] = cfg_data_i;
        vls_pkg::CFG_MIN_Y: bnd_lo_d[1] = cfg_data_i;
        vls_pkg::CFG_MIN_Z: bnd_lo_d[2] = cfg_data_i;
        vls_pkg::CFG_MAX_X: bnd_hi_d[0] = cfg_data_i;
        vls_pkg::CFG_MAX_Y: bnd_hi_d[1] = cfg_data_i;
        vls_pkg::CFG_MAX_Z: bnd_hi_d[2] = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pos_d[0]    = s_axis_tdata[31:0];
          pos_d[1]    = s_axis_tdata[63:32];
          pos_d[2]    = s_axis_tdata[95:64];
          rad_d       = s_axis_tdata[127:96];
          col_d[0]    = s_axis_tdata[135:128];
          col_d[1]    = s_axis_tdata[143:136];
          col_d[2]    = s_axis_tdata[151:144];
          idx_d       = IXW'(s_axis_tdata[233:216]);
          res_rgba_d  = '0;
          res_taken_d = 1'b0;
          a_d         = '0;
          case (cmd_in)
            vls_pkg::CMD_CLEAR: begin
              clr_d     = '0;
              clr_cmd_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            vls_pkg::CMD_INJECT: begin
              // Drop expired lights and zero or negative radii at once
              if ((s_axis_tdata[183:152] < s_axis_tdata[215:184]) ||
                  s_axis_tdata[127] || (s_axis_tdata[127:96] == 32'd0)) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_AXIS;
              end
            end
            vls_pkg::CMD_READ: begin
              if (UW'(s_axis_tdata[233:216]) < UW'(VOXELS)) begin
                state_d = ST_RREAD;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == AW'(VOXELS - 1)) begin
          state_d = clr_cmd_q ? ST_DONE : ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_AXIS: begin
        if ((a_q == 2'd0) || (size_s > ext_q)) begin
          ext_d = size_s;
        end
        if (ax_far || (diff_s[32] && ax_neg_out)) begin
          state_d = ST_DONE;
        end else if (diff_s[32]) begin
          v_d[a_q] = '0;
          if (a_q == 2'd2) begin
            state_d = ST_SPAN;
          end else begin
            a_d = a_q + 1'b1;
          end
        end else begin
          ureq.start = 1'b1;
          ureq.op    = vls_pkg::OP_DIV;
          ureq.rem   = mag_side;
          ureq.tinit = UW'(33'(s_clamp)) << (QA - 1);
          ureq.steps = vls_pkg::STEPW'(QA);
          state_d    = ST_AXWAIT;
        end
      end

      ST_AXWAIT: begin
        if (!ursp.busy) begin
          v_d[a_q] = ursp.acc[VW-1:0];
          if (a_q == 2'd2) begin
            state_d = ST_SPAN;
          end else begin
            a_d     = a_q + 1'b1;
            state_d = ST_AXIS;
          end
        end
      end

      ST_SPAN: begin
        if (ext_le0 || (denom >= ext_max)) begin
          span_d  = SPW'(MAXR);
          state_d = ST_BOUND;
        end else begin
          ureq.start = 1'b1;
          ureq.op    = vls_pkg::OP_DIV;
          ureq.rem   = denom;
          ureq.tinit = UW'(ext_pos) << (QS - 1);
          ureq.steps = vls_pkg::STEPW'(QS);
          state_d    = ST_SPWAIT;
        end
      end

      ST_SPWAIT: begin
        if (!ursp.busy) begin
          span_d  = SPW'(ursp.acc[QS-1:0] + QS'(1));
          state_d = ST_BOUND;
        end
      end

      ST_BOUND: begin
        lo_d    = lo_c;
        hi_d    = hi_c;
        x_d     = lo_c[0];
        y_d     = lo_c[1];
        z_d     = lo_c[2];
        state_d = ST_VOX;
      end

      ST_VOX: begin
        if (ext_le0) begin
          aq_d    = 17'h10000;
          state_d = ST_VRD;
        end else begin
          ureq.start = 1'b1;
          ureq.op    = vls_pkg::OP_SQRT;
          ureq.rem   = UW'(d2) << 32;
          ureq.tinit = UW'(1) << SE;
          ureq.steps = vls_pkg::STEPW'(SQ_STEPS);
          state_d    = ST_SQWAIT;
        end
      end

      ST_SQWAIT: begin
        if (!ursp.busy) begin
          prod_d  = mul_w;
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        // Skip voxels beyond the light's reach
        if (UW'(prod_q) >= den16) begin
          state_d = ST_NEXT;
        end else begin
          ureq.start = 1'b1;
          ureq.op    = vls_pkg::OP_DIV;
          ureq.rem   = UW'(prod_q);
          ureq.tinit = denom << 15;
          ureq.steps = vls_pkg::STEPW'(16);
          state_d    = ST_ATWAIT;
        end
      end

      ST_ATWAIT: begin
        if (!ursp.busy) begin
          aq_d    = 17'h10000 - {1'b0, ursp.acc[15:0]};
          state_d = ST_VRD;
        end
      end

      ST_VRD: state_d = ST_VWR;

      ST_VWR: begin
        mem_we  = 1'b1;
        state_d = ST_NEXT;
      end

      ST_NEXT: begin
        if (x1 != hi_q[0]) begin
          x_d     = x1[VW-1:0];
          state_d = ST_VOX;
        end else begin
          x_d = lo_q[0];
          if (y1 != hi_q[1]) begin
            y_d     = y1[VW-1:0];
            state_d = ST_VOX;
          end else begin
            y_d = lo_q[1];
            if (z1 != hi_q[2]) begin
              z_d     = z1[VW-1:0];
              state_d = ST_VOX;
            end else begin
              res_taken_d = 1'b1;
              state_d     = ST_DONE;
            end
          end
        end
      end

      ST_RREAD: state_d = ST_RDATA;

      ST_RDATA: begin
        res_rgba_d = rdata_q;
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_rgba_d  = res_rgba_q;
          out_taken_d = res_taken_q;
          clr_cmd_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cmd_q   <= 1'b0;
      out_valid_q <= 1'b0;
      bnd_lo_q    <= '0;
      bnd_hi_q    <= '0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_cmd_q   <= clr_cmd_d;
      out_valid_q <= out_valid_d;
      bnd_lo_q    <= bnd_lo_d;
      bnd_hi_q    <= bnd_hi_d;
      clr_q       <= clr_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    rad_q       <= rad_d;
    col_q       <= col_d;
    idx_q       <= idx_d;
    a_q         <= a_d;
    ext_q       <= ext_d;
    v_q         <= v_d;
    span_q      <= span_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    x_q         <= x_d;
    y_q         <= y_d;
    z_q         <= z_d;
    prod_q      <= prod_d;
    aq_q        <= aq_d;
    res_rgba_q  <= res_rgba_d;
    res_taken_q <= res_taken_d;
    out_rgba_q  <= out_rgba_d;
    out_taken_q <= out_taken_d;
  end

  // Grid memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      voxel_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= voxel_mem[mem_raddr];
  end

  vls_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .rsp_o  (ursp)
  );

`ifndef NO_ASSERTIONS
  a_unit_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ureq.start |-> !ursp.busy)
    else $error("shared unit started while busy");

  a_mem_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_VWR || state_q == ST_CLEAR))
    else $error("grid written outside a write state");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_voxel_in_cube: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VOX) |-> (({1'b0, x_q} < hi_q[0]) && (x_q >= lo_q[0]) &&
                             ({1'b0, z_q} < hi_q[2]) && (z_q >= lo_q[2])))
    else $error("voxel walk left the cube");
`endif

endmodule

// ----- design/vls_unit.sv -----
// ============================================================================
// vls_unit: shared bit-serial divide and square root unit
// Restoring division (one quotient bit per cycle) or integer square root
// (two radicand bits per cycle) over one compare and subtract.
// ============================================================================
module vls_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vls_pkg::vls_ureq_t  req_i,
  output vls_pkg::vls_ursp_t  rsp_o
);

  logic [vls_pkg::UW-1:0]    rem_q, rem_d;
  logic [vls_pkg::UW-1:0]    t_q, t_d;
  logic [vls_pkg::UW-1:0]    acc_q, acc_d;
  logic [vls_pkg::STEPW-1:0] cnt_q;
  logic                      busy_q;
  vls_pkg::vls_op_e          op_q;
  logic [vls_pkg::UW-1:0]    cand;
  logic                      ge;

  // One recurrence step
  always_comb begin
    cand  = (op_q == vls_pkg::OP_DIV) ? t_q : acc_q + t_q;
    ge    = (rem_q >= cand);
    rem_d = ge ? rem_q - cand : rem_q;
    if (op_q == vls_pkg::OP_DIV) begin
      acc_d = {acc_q[vls_pkg::UW-2:0], ge};
      t_d   = t_q >> 1;
    end else begin
      acc_d = ge ? (acc_q >> 1) + t_q : acc_q >> 1;
      t_d   = t_q >> 2;
    end
  end

  // Step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == vls_pkg::STEPW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      t_q   <= req_i.tinit;
      acc_q <= '0;
      op_q  <= req_i.op;
    end else if (busy_q) begin
      rem_q <= rem_d;
      t_q   <= t_d;
      acc_q <= acc_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.acc  = acc_q;

endmodule

// ----- dv/voxel_light_splat_tb.sv -----
// ----------------------------------------------------------------------------
// voxel_light_splat_tb: self-checking bench for the voxel light splat block
// Drives clear, inject and read commands over the input stream with random
// gaps and output stalls. A local grid model predicts the responses but for
// directed rows with a fixed expectation; responses are checked in order. The
// run walks several world-bound settings: reset (empty), unit cube per voxel,
// full 32-bit extremes, inverted and mixed per-axis sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_light_splat_tb;

  localparam int          SIDE        = 64;
  localparam int          SPAN_MAX    = 8;
  localparam longint      ONE_Q       = 65536;
  localparam int          IDLE_LIMIT  = 1500000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [2:0]  CFG_SPARE_A = 3'd6;
  localparam logic [2:0]  CFG_SPARE_B = 3'd7;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] px, py, pz, rad;
    logic [7:0]  red, grn, blu;
    logic [31:0] expire, now;
    logic [17:0] vidx;
  } light_cmd_t;

  typedef struct {
    logic [7:0] red, grn, blu, alp;
    logic       taken;
  } voxel_rsp_t;

  typedef struct {
    light_cmd_t c;
    bit         fixed;
    voxel_rsp_t r;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [vls_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [vls_pkg::IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [vls_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [vls_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [vls_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Model state: grid words (absent means zero) and bounds
  logic [31:0] grid_words [int unsigned];
  longint      bnd_lo [3];
  longint      bnd_hi [3];

  voxel_rsp_t  rsp_q [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          moved = 1'b0;
  bit          long_hold = 1'b0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  int          last_v [3] = '{0, 0, 0};

  voxel_light_splat dut (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] sat_add(logic [7:0] a, longint unsigned b);
    longint unsigned s = a + b;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // Splat one light into the model grid; returns 1 when taken
  function automatic bit splat_light(light_cmd_t c);
    longint rad = longint'(signed'(c.rad));
    longint pos [3];
    longint v [3], lo [3], hi [3];
    longint ext = 0, span, size, s, dx, dy, dz;
    longint unsigned denom, dq, q, aq;
    logic [7:0] col [3];
    logic [31:0] w;
    int unsigned ix;
    pos[0] = longint'(signed'(c.px));
    pos[1] = longint'(signed'(c.py));
    pos[2] = longint'(signed'(c.pz));
    col[0] = c.red; col[1] = c.grn; col[2] = c.blu;
    if (c.expire < c.now) return 1'b0;
    if (rad <= 0) return 1'b0;
    for (int a = 0; a < 3; a++) begin
      size = bnd_hi[a] - bnd_lo[a];
      s = (size < ONE_Q) ? ONE_Q : size;
      if (a == 0 || size > ext) ext = size;
      v[a] = ((pos[a] - bnd_lo[a]) * SIDE) / s;
      if (v[a] < 0 || v[a] >= SIDE) return 1'b0;
    end
    if (ext <= 0) begin
      span = SPAN_MAX;
    end else begin
      span = (rad * SIDE) / ext + 1;
      if (span > SPAN_MAX) span = SPAN_MAX;
    end
    for (int a = 0; a < 3; a++) begin
      lo[a] = (v[a] - span < 0) ? 0 : v[a] - span;
      hi[a] = (v[a] + span > SIDE) ? SIDE : v[a] + span;
      last_v[a] = int'(v[a]);
    end
    denom = SIDE * rad;
    for (longint z = lo[2]; z < hi[2]; z++)
      for (longint y = lo[1]; y < hi[1]; y++)
        for (longint x = lo[0]; x < hi[0]; x++) begin
          dx = x - v[0]; dy = y - v[1]; dz = z - v[2];
          if (ext <= 0) begin
            aq = ONE_Q;
          end else begin
            dq = int_sqrt(longint'(dx * dx + dy * dy + dz * dz) << 32);
            q = (dq * longint'(ext)) / denom;
            if (q >= ONE_Q) continue;
            aq = ONE_Q - q;
          end
          ix = int'((z * SIDE + y) * SIDE + x);
          w = grid_words.exists(ix) ? grid_words[ix] : 32'd0;
          w[7:0]   = sat_add(w[7:0],   (col[0] * aq) >> 16);
          w[15:8]  = sat_add(w[15:8],  (col[1] * aq) >> 16);
          w[23:16] = sat_add(w[23:16], (col[2] * aq) >> 16);
          w[31:24] = 8'd255;
          grid_words[ix] = w;
        end
    return 1'b1;
  endfunction

  // Apply one command to the model and return its response
  function automatic voxel_rsp_t predict_voxel(light_cmd_t c);
    voxel_rsp_t r = '{default: '0};
    logic [31:0] w;
    case (c.cmd)
      vls_pkg::CMD_CLEAR:  grid_words.delete();
      vls_pkg::CMD_INJECT: r.taken = splat_light(c);
      vls_pkg::CMD_READ: begin
        w = grid_words.exists(int'(c.vidx)) ? grid_words[int'(c.vidx)] : 32'd0;
        {r.alp, r.blu, r.grn, r.red} = w;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Pick a position on one axis, mostly inside the grid
  function automatic logic [31:0] pick_pos(int a);
    longint size = bnd_hi[a] - bnd_lo[a];
    longint s = (size < ONE_Q) ? ONE_Q : size;
    longint unsigned off;
    if ($urandom_range(0, 9) == 0) return $urandom;
    off = (longint'($urandom) * s) >> 32;
    return 32'(bnd_lo[a] + longint'(off));
  endfunction

  function automatic light_cmd_t rand_cmd();
    light_cmd_t c;
    int sel = $urandom_range(0, 99);
    longint ext = bnd_hi[0] - bnd_lo[0];
    int vx;
    for (int a = 1; a < 3; a++)
      if (bnd_hi[a] - bnd_lo[a] > ext) ext = bnd_hi[a] - bnd_lo[a];
    c.px = $urandom; c.py = $urandom; c.pz = $urandom; c.rad = $urandom;
    c.red = $urandom; c.grn = $urandom; c.blu = $urandom;
    c.expire = $urandom; c.now = $urandom; c.vidx = $urandom;
    if (sel < 1) begin
      c.cmd = vls_pkg::CMD_CLEAR;
    end else if (sel < 3) begin
      c.cmd = CMD_UNUSED;
    end else if (sel < 45) begin
      c.cmd = vls_pkg::CMD_READ;
      // read close to the last light most of the time
      if (sel < 35) begin
        c.vidx = '0;
        for (int a = 2; a >= 0; a--) begin
          vx = last_v[a] + $urandom_range(0, 6) - 3;
          vx = (vx < 0) ? 0 : (vx >= SIDE) ? SIDE - 1 : vx;
          c.vidx = c.vidx * SIDE + vx;
        end
      end
    end else begin
      c.cmd = vls_pkg::CMD_INJECT;
      if (sel < 92) begin
        c.px = pick_pos(0); c.py = pick_pos(1); c.pz = pick_pos(2);
        if (ext > 0)
          c.rad = $urandom_range(1, (ext / 32 > 1) ? int'(ext / 32) : 1);
        else
          c.rad = $urandom_range(1, 32'h7fffffff);
        if ($urandom_range(0, 1)) c.expire = 32'hffffffff - $urandom_range(0, 65535);
        else c.now = $urandom_range(0, 65535);
      end else if (sel < 96) begin
        c.px = pick_pos(0); c.py = pick_pos(1); c.pz = pick_pos(2);
        c.rad = -$urandom_range(0, 32'h7fffffff);
      end
    end
    return c;
  endfunction

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx <= vls_pkg::CFG_MIN_Z) bnd_lo[idx] = longint'(signed'(val));
    else if (idx <= vls_pkg::CFG_MAX_Z) bnd_hi[idx - vls_pkg::CFG_MAX_X] = longint'(signed'(val));
    @(posedge clk_i);
  endtask

  task automatic set_bounds(logic [31:0] lx, ly, lz, hx, hy, hz);
    write_cfg(vls_pkg::CFG_MIN_X, lx);
    write_cfg(vls_pkg::CFG_MIN_Y, ly);
    write_cfg(vls_pkg::CFG_MIN_Z, lz);
    write_cfg(vls_pkg::CFG_MAX_X, hx);
    write_cfg(vls_pkg::CFG_MAX_Y, hy);
    write_cfg(vls_pkg::CFG_MAX_Z, hz);
  endtask

  // Offer one command, hold it until the transfer, log its response
  task automatic send_cmd(light_cmd_t c, bit fixed, voxel_rsp_t r);
    int gap = quiet_in ? 0 : $urandom_range(0, 8);
    voxel_rsp_t p;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.cmd;
    s_axis_tdata  <= {6'd0, c.vidx, c.now, c.expire, c.blu, c.grn, c.red,
                      c.rad, c.pz, c.py, c.px};
    do @(negedge clk_i); while (!s_axis_tready);
    p = predict_voxel(c);
    rsp_q.push_back(fixed ? r : p);
    @(posedge clk_i);
    if ($urandom_range(0, 19) == 0) quiet_in = !quiet_in;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (rsp_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Output side: random stalls, one long hold on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = long_hold ? 400 : (quiet_out ? 0 : $urandom_range(0, 8));
      long_hold = 1'b0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      @(posedge clk_i);
      if ($urandom_range(0, 19) == 0) quiet_out = !quiet_out;
    end
  end

  // Compare each response with the oldest expectation
  always @(negedge clk_i) begin
    voxel_rsp_t e;
    moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid_i && cfg_ready_o);
    if (m_axis_tvalid && m_axis_tready) begin
      if (rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h/%h", m_axis_tdata, m_axis_tuser);
      end else begin
        e = rsp_q.pop_front();
        if (m_axis_tdata !== {e.alp, e.blu, e.grn, e.red} || m_axis_tuser !== e.taken) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rgba %h taken %b, got %h taken %b",
                     {e.alp, e.blu, e.grn, e.red}, e.taken, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    idle_cycles <= moved ? 0 : idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t   tab [16];
    light_cmd_t c;
    voxel_rsp_t z = '{default: '0};
    voxel_rsp_t none = '{default: '0};
    light_cmd_t b = '{cmd: vls_pkg::CMD_INJECT, px: 32'h8000, py: 32'h8000,
                      pz: 32'h8000, rad: 32'h10000, red: 8'hff, grn: 8'h80,
                      blu: 8'h01, expire: 32'd5, now: 32'd5, vidx: '0};
    // Directed rows at reset bounds (empty grid extent, full-color cubes)
    foreach (tab[i]) tab[i] = '{c: b, fixed: 1'b0, r: z};
    tab[0].c.cmd = vls_pkg::CMD_READ; tab[0].fixed = 1;
    tab[1].c.cmd = vls_pkg::CMD_READ; tab[1].c.vidx = '1; tab[1].fixed = 1;
    tab[2].c.cmd = CMD_UNUSED; tab[2].c.vidx = '1; tab[2].fixed = 1;
    tab[3].c.expire = 32'd0; tab[3].c.now = 32'd1; tab[3].fixed = 1;
    tab[4].c.rad = 32'd0; tab[4].fixed = 1;
    tab[5].c.rad = 32'h80000000; tab[5].fixed = 1;
    tab[6].c.px = -32'sd65536; tab[6].fixed = 1;
    tab[7].c.pz = 32'h10000; tab[7].fixed = 1;
    tab[8].c.px = 32'h7fffffff; tab[8].fixed = 1;
    // light at voxel (32,32,32), twice to saturate red
    tab[9].c.expire = 32'hffffffff; tab[9].c.now = 32'hffffffff;
    tab[10].c.rad = 32'h7fffffff; tab[10].c.now = 32'd0;
    tab[11].c.cmd = vls_pkg::CMD_READ; tab[11].c.vidx = 18'd133152;
    tab[12].c.cmd = vls_pkg::CMD_READ; tab[12].c.vidx = 18'd133152 + 18'd4096 * 7;
    tab[13].c.px = 32'd0; tab[13].c.py = 32'hffff; tab[13].c.pz = 32'd0;
    tab[14].c.cmd = vls_pkg::CMD_CLEAR;
    tab[15].c.cmd = vls_pkg::CMD_READ; tab[15].c.vidx = 18'd133152;
    tab[15].fixed = 1;

    grid_words.delete();
    bnd_lo = '{0, 0, 0};
    bnd_hi = '{0, 0, 0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tab[i]) send_cmd(tab[i].c, tab[i].fixed, tab[i].r);
    // sender pause until every response is back
    drain();

    // One voxel per world unit on each axis
    set_bounds(0, 0, 0, 32'h400000, 32'h400000, 32'h400000);
    for (int i = 0; i < 45; i++) begin
      if (i == 20) begin
        long_hold = 1'b1;
        quiet_in = 1'b1;
      end
      c = rand_cmd();
      if (i >= 20 && i < 32) c.cmd = vls_pkg::CMD_READ;
      send_cmd(c, 1'b0, none);
    end
    drain();

    // Full 32-bit world extent
    set_bounds(32'h80000000, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    for (int i = 0; i < 35; i++) send_cmd(rand_cmd(), 1'b0, none);
    drain();

    // Inverted bounds: every cube at full span and color
    set_bounds(32'h400000, 32'h400000, 32'h400000, 32'h0, 32'hffff0000, 32'h0);
    for (int i = 0; i < 20; i++) send_cmd(rand_cmd(), 1'b0, none);
    drain();

    // Mixed axis sizes; spare indexes must be ignored
    set_bounds(32'hfff00000, 32'h0, 32'h0, 32'h300000, 32'h200000, 32'h800000);
    write_cfg(CFG_SPARE_A, 32'hffffffff);
    write_cfg(CFG_SPARE_B, 32'h12345678);
    for (int i = 0; i < 24; i++) send_cmd(rand_cmd(), 1'b0, none);
    drain();

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && rsp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
